### hdl/qiwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qiwt_pkg
// Shared constants, codes and types of the in-flight window tracker.
// ----------------------------------------------------------------------------
package qiwt_pkg;

  localparam int unsigned QueueDepth   = 64;
  localparam int unsigned AddrW        = $clog2(QueueDepth);
  localparam int unsigned CntW         = AddrW + 1;
  localparam int unsigned MaxResults   = 64;
  localparam int unsigned ResCntW      = $clog2(MaxResults + 1);
  localparam int unsigned CmdFifoDepth = 2;
  localparam int unsigned CmdPtrW      = $clog2(CmdFifoDepth);
  localparam int unsigned CmdCntW      = $clog2(CmdFifoDepth + 1);

  // input operation codes
  localparam logic [2:0] OP_PUBLISH = 3'd0;
  localparam logic [2:0] OP_PUBACK  = 3'd1;
  localparam logic [2:0] OP_PUBREC  = 3'd2;
  localparam logic [2:0] OP_PUBCOMP = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // result action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PUBLISH = 2'd1;
  localparam logic [1:0] ACT_PUBREL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_START_ID = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUB,
    CMD_PUB_QOS0,
    CMD_ACK,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] pid;
    logic [1:0]  qos;
    logic [31:0] now;
    logic        want_rel;
    logic [1:0]  want_lvl;
    logic        is_pubrec;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pid;
    logic [1:0]  qos;
    logic        retx;
    logic        matched;
    logic        ovf;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic        rel;
    logic [1:0]  lvl;
    logic [31:0] sent;
  } entry_t;

  typedef struct packed {
    logic [6:0]  window;
    logic [31:0] interval;
    logic        id_load;
    logic [15:0] id_seed;
  } cfg_t;

  // Build the send result for a stored entry.
  function automatic res_t entry_res(entry_t e, logic retx, logic matched, logic last);
    res_t r;
    r.action  = e.rel ? ACT_PUBREL : ACT_PUBLISH;
    r.pid     = e.id;
    r.qos     = e.rel ? 2'd0 : e.lvl;
    r.retx    = retx;
    r.matched = matched;
    r.ovf     = 1'b0;
    r.last    = last;
    return r;
  endfunction

  // Result that sends nothing.
  function automatic res_t idle_res(logic matched);
    res_t r;
    r         = '0;
    r.action  = ACT_NONE;
    r.matched = matched;
    r.last    = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/qiwt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qiwt_front
// Decode incoming words into commands and hold them in a short queue.
// ----------------------------------------------------------------------------
module qiwt_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [2:0]           op_i,
  input  wire  [15:0]          pid_i,
  input  wire  [1:0]           qos_i,
  input  wire  [31:0]          now_i,
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i,
  output qiwt_pkg::cmd_t       cmd_o
);

  qiwt_pkg::cmd_t                      dec;
  qiwt_pkg::cmd_t                      fifo_q [qiwt_pkg::CmdFifoDepth];
  logic [qiwt_pkg::CmdPtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [qiwt_pkg::CmdCntW-1:0]        cnt_q, cnt_d;
  logic                                push, pop;

  // classify
  always_comb begin
    dec           = '0;
    dec.pid       = pid_i;
    dec.qos       = qos_i;
    dec.now       = now_i;
    dec.want_rel  = (op_i == qiwt_pkg::OP_PUBCOMP);
    dec.want_lvl  = (op_i == qiwt_pkg::OP_PUBACK) ? 2'd1 : 2'd2;
    dec.is_pubrec = (op_i == qiwt_pkg::OP_PUBREC);
    unique case (op_i)
      qiwt_pkg::OP_PUBLISH: begin
        if (qos_i == 2'd0) begin
          dec.kind = qiwt_pkg::CMD_PUB_QOS0;
        end else if (qos_i == 2'd3) begin
          dec.kind = qiwt_pkg::CMD_NOP;
        end else begin
          dec.kind = qiwt_pkg::CMD_PUB;
        end
      end
      qiwt_pkg::OP_PUBACK, qiwt_pkg::OP_PUBREC, qiwt_pkg::OP_PUBCOMP: begin
        dec.kind = qiwt_pkg::CMD_ACK;
      end
      qiwt_pkg::OP_TICK: begin
        dec.kind = qiwt_pkg::CMD_TICK;
      end
      default: begin
        dec.kind = qiwt_pkg::CMD_NOP;
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != qiwt_pkg::CmdCntW'(qiwt_pkg::CmdFifoDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + qiwt_pkg::CmdPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + qiwt_pkg::CmdPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + qiwt_pkg::CmdCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - qiwt_pkg::CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

### hdl/qiwt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qiwt_engine
// Execute commands against the ordered entry queue and emit result words.
// ----------------------------------------------------------------------------
module qiwt_engine (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  qiwt_pkg::cfg_t       cfg_i,
  input  wire                  cmd_valid_i,
  output logic                 cmd_ready_o,
  input  qiwt_pkg::cmd_t       cmd_i,
  output logic                 res_valid_o,
  input  wire                  res_ready_i,
  output qiwt_pkg::res_t       res_o
);

  localparam int unsigned AW = qiwt_pkg::AddrW;
  localparam int unsigned CW = qiwt_pkg::CntW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FINAL    = 4'd1;
  localparam logic [3:0] S_PUB_CHK  = 4'd2;
  localparam logic [3:0] S_ACK_SCAN = 4'd3;
  localparam logic [3:0] S_SHIFT    = 4'd4;
  localparam logic [3:0] S_PROM     = 4'd5;
  localparam logic [3:0] S_PROM_WR  = 4'd6;
  localparam logic [3:0] S_REL      = 4'd7;
  localparam logic [3:0] S_TICK     = 4'd8;

  logic [3:0]              state_q, state_d;
  qiwt_pkg::cmd_t          cmd_q, cmd_d;
  logic [CW-1:0]           qc_q, qc_d, ic_q, ic_d;
  logic [15:0]             next_id_q, next_id_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [AW-1:0]           chk_idx_q, chk_idx_d;
  logic [CW-1:0]           sh_rd_q, sh_rd_d;
  logic [AW-1:0]           sh_wr_q, sh_wr_d;
  logic                    sh_pend_q, sh_pend_d;
  qiwt_pkg::res_t          fin_q, fin_d;
  qiwt_pkg::res_t          pend_q, pend_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [qiwt_pkg::ResCntW-1:0] hits_q, hits_d;
  logic                    emitted_q, emitted_d;
  qiwt_pkg::res_t          out_q;
  logic                    out_vld_q;

  qiwt_pkg::entry_t        entry_mem_q [qiwt_pkg::QueueDepth];
  qiwt_pkg::entry_t        rdata_q;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_wa, mem_ra;
  qiwt_pkg::entry_t        mem_wd;

  logic                    can_emit, emit_en;
  qiwt_pkg::res_t          emit_res;
  logic                    in_window, ack_hit, tick_hit, go_pred, dup;
  logic [31:0]             age;

  assign can_emit  = !out_vld_q || res_ready_i;
  assign in_window = (32'(ic_q) < 32'(cfg_i.window));
  assign ack_hit   = chk_vld_q && (rdata_q.id == cmd_q.pid) &&
                     (rdata_q.rel == cmd_q.want_rel) &&
                     (cmd_q.want_rel || (rdata_q.lvl == cmd_q.want_lvl));
  assign age       = cmd_q.now - rdata_q.sent;
  assign tick_hit  = chk_vld_q && (age >= cfg_i.interval) &&
                     (32'(hits_q) < 32'(qiwt_pkg::MaxResults));
  assign go_pred   = cmd_q.is_pubrec && (qc_q == ic_q + CW'(1)) &&
                     (32'(ic_q) + 32'd1 < 32'(cfg_i.window));
  assign dup       = (rdata_q.id == cmd_q.pid) && (rdata_q.lvl == cmd_q.qos) && !rdata_q.rel;
  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    qc_d       = qc_q;
    ic_d       = ic_q;
    next_id_d  = next_id_q;
    scan_d     = scan_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    sh_rd_d    = sh_rd_q;
    sh_wr_d    = sh_wr_q;
    sh_pend_d  = sh_pend_q;
    fin_d      = fin_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    hits_d     = hits_q;
    emitted_d  = emitted_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = qc_q[AW-1:0];
    mem_ra     = scan_q[AW-1:0];
    mem_wd     = '0;
    emit_en    = 1'b0;
    emit_res   = fin_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          scan_d    = '0;
          chk_vld_d = 1'b0;
          unique case (cmd_i.kind)
            qiwt_pkg::CMD_PUB_QOS0: begin
              fin_d        = qiwt_pkg::idle_res(1'b0);
              fin_d.action = qiwt_pkg::ACT_PUBLISH;
              state_d      = S_FINAL;
            end
            qiwt_pkg::CMD_PUB: begin
              // take the next id whatever happens to the request
              cmd_d.pid = next_id_q;
              next_id_d = next_id_q + 16'd1;
              if (32'(qc_q) >= 32'(qiwt_pkg::QueueDepth)) begin
                fin_d     = qiwt_pkg::idle_res(1'b0);
                fin_d.pid = next_id_q;
                fin_d.ovf = 1'b1;
                state_d   = S_FINAL;
              end else if (qc_q == ic_q) begin
                mem_we  = 1'b1;
                mem_wd  = '{id: next_id_q, rel: 1'b0, lvl: cmd_i.qos, sent: cmd_i.now};
                qc_d    = qc_q + CW'(1);
                fin_d   = qiwt_pkg::idle_res(1'b0);
                if (in_window) begin
                  ic_d         = ic_q + CW'(1);
                  fin_d.action = qiwt_pkg::ACT_PUBLISH;
                  fin_d.pid    = next_id_q;
                  fin_d.qos    = cmd_i.qos;
                end
                state_d = S_FINAL;
              end else begin
                // look at the tail entry before queueing behind it
                mem_re  = 1'b1;
                mem_ra  = AW'(qc_q - CW'(1));
                state_d = S_PUB_CHK;
              end
            end
            qiwt_pkg::CMD_ACK: begin
              state_d = S_ACK_SCAN;
            end
            qiwt_pkg::CMD_TICK: begin
              pend_vld_d = 1'b0;
              hits_d     = '0;
              state_d    = S_TICK;
            end
            default: begin
              fin_d   = qiwt_pkg::idle_res(1'b0);
              state_d = S_FINAL;
            end
          endcase
        end
      end

      S_FINAL: begin
        if (can_emit) begin
          emit_en  = 1'b1;
          emit_res = fin_q;
          state_d  = S_IDLE;
        end
      end

      S_PUB_CHK: begin
        if (!dup) begin
          mem_we = 1'b1;
          mem_wd = '{id: cmd_q.pid, rel: 1'b0, lvl: cmd_q.qos, sent: 32'd0};
          qc_d   = qc_q + CW'(1);
        end
        fin_d   = qiwt_pkg::idle_res(1'b0);
        state_d = S_FINAL;
      end

      S_ACK_SCAN: begin
        if (ack_hit) begin
          sh_rd_d   = CW'(chk_idx_q) + CW'(1);
          sh_pend_d = 1'b0;
          state_d   = S_SHIFT;
        end else if (scan_q < ic_q) begin
          mem_re    = 1'b1;
          mem_ra    = scan_q[AW-1:0];
          chk_idx_d = scan_q[AW-1:0];
          chk_vld_d = 1'b1;
          scan_d    = scan_q + CW'(1);
        end else begin
          chk_vld_d = 1'b0;
          if (!chk_vld_q) begin
            fin_d   = qiwt_pkg::idle_res(1'b0);
            state_d = S_FINAL;
          end
        end
      end

      S_SHIFT: begin
        // move each later entry down one place, one per cycle
        if (sh_pend_q) begin
          mem_we = 1'b1;
          mem_wa = sh_wr_q;
          mem_wd = rdata_q;
        end
        if (sh_rd_q < qc_q) begin
          mem_re    = 1'b1;
          mem_ra    = sh_rd_q[AW-1:0];
          sh_wr_d   = AW'(sh_rd_q - CW'(1));
          sh_pend_d = 1'b1;
          sh_rd_d   = sh_rd_q + CW'(1);
        end else begin
          sh_pend_d = 1'b0;
          if (!sh_pend_q) begin
            qc_d      = qc_q - CW'(1);
            ic_d      = ic_q - CW'(1);
            emitted_d = 1'b0;
            state_d   = S_PROM;
          end
        end
      end

      S_PROM: begin
        if (qc_q > ic_q) begin
          mem_re  = 1'b1;
          mem_ra  = ic_q[AW-1:0];
          state_d = S_PROM_WR;
        end else begin
          state_d = S_REL;
        end
      end

      S_PROM_WR: begin
        if (can_emit) begin
          mem_we      = 1'b1;
          mem_wa      = ic_q[AW-1:0];
          mem_wd      = rdata_q;
          mem_wd.sent = cmd_q.now;
          emit_en     = 1'b1;
          emit_res    = qiwt_pkg::entry_res(rdata_q, 1'b0, 1'b1, !go_pred);
          ic_d        = ic_q + CW'(1);
          emitted_d   = 1'b1;
          state_d     = cmd_q.is_pubrec ? S_REL : S_IDLE;
        end
      end

      S_REL: begin
        if (can_emit) begin
          state_d = S_IDLE;
          if (cmd_q.is_pubrec) begin
            mem_we = 1'b1;
            mem_wd = '{id: cmd_q.pid, rel: 1'b1, lvl: 2'd0, sent: cmd_q.now};
            qc_d   = qc_q + CW'(1);
            if ((qc_q == ic_q) && in_window) begin
              ic_d            = ic_q + CW'(1);
              emit_en         = 1'b1;
              emit_res        = qiwt_pkg::idle_res(1'b1);
              emit_res.action = qiwt_pkg::ACT_PUBREL;
              emit_res.pid    = cmd_q.pid;
            end else if (!emitted_q) begin
              emit_en  = 1'b1;
              emit_res = qiwt_pkg::idle_res(1'b1);
            end
          end else begin
            emit_en  = 1'b1;
            emit_res = qiwt_pkg::idle_res(1'b1);
          end
        end
      end

      S_TICK: begin
        // hold one hit back so the final one can carry last
        if (!(tick_hit && pend_vld_q && !can_emit)) begin
          if (tick_hit) begin
            if (pend_vld_q) begin
              emit_en  = 1'b1;
              emit_res = pend_q;
            end
            pend_d     = qiwt_pkg::entry_res(rdata_q, 1'b1, 1'b0, 1'b0);
            pend_vld_d = 1'b1;
            hits_d     = hits_q + qiwt_pkg::ResCntW'(1);
          end
          if (scan_q < ic_q) begin
            mem_re    = 1'b1;
            mem_ra    = scan_q[AW-1:0];
            chk_vld_d = 1'b1;
            scan_d    = scan_q + CW'(1);
          end else begin
            chk_vld_d = 1'b0;
            if (!chk_vld_q) begin
              if (pend_vld_q) begin
                fin_d      = pend_q;
                fin_d.last = 1'b1;
              end else begin
                fin_d = qiwt_pkg::idle_res(1'b0);
              end
              state_d = S_FINAL;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.id_load) begin
      next_id_d = cfg_i.id_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      qc_q       <= '0;
      ic_q       <= '0;
      next_id_q  <= '0;
      chk_vld_q  <= 1'b0;
      sh_pend_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      emitted_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      qc_q       <= qc_d;
      ic_q       <= ic_d;
      next_id_q  <= next_id_d;
      chk_vld_q  <= chk_vld_d;
      sh_pend_q  <= sh_pend_d;
      pend_vld_q <= pend_vld_d;
      emitted_q  <= emitted_d;
      out_vld_q  <= emit_en || (out_vld_q && !res_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    sh_rd_q   <= sh_rd_d;
    sh_wr_q   <= sh_wr_d;
    fin_q     <= fin_d;
    pend_q    <= pend_d;
    hits_q    <= hits_d;
    if (emit_en) begin
      out_q <= emit_res;
    end
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= entry_mem_q[mem_ra];
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

### hdl/qos_inflight_window_tracker.sv
// A publish or an unknown op passes through the final state into the output register.
// An acknowledgement scans the in-flight entries one per cycle, then closes the gap one
// entry per cycle through the entry store.
// A timer tick scans the in-flight entries one per cycle while the output takes resends.
// One item is worked at a time; a two-word command queue and the output register decouple.
// Reset clears counters and control; the entry store is not cleared (no clearing pass).
`default_nettype none
// ----------------------------------------------------------------------------
// qos_inflight_window_tracker
// Outbound QoS in-flight window: ordered entry queue, acks, resends.
// ----------------------------------------------------------------------------
module qos_inflight_window_tracker (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input words
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [55:0] s_axis_tdata,   // pkt_id[15:0], qos[17:16], now_time[49:18], zero pad
  input  wire  [2:0]  s_axis_tuser,   // op[2:0]
  // result words
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_pkt_id[15:0], out_qos[17:16], retransmit[18],
                                      // ack_matched[19], queue_overflow[20], zero pad
  output logic [1:0]  m_axis_tuser,   // action[1:0]
  output logic        m_axis_tlast,
  // register writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  qiwt_pkg::cfg_t  cfg;
  logic [6:0]      window_q;
  logic [31:0]     interval_q;
  logic            cfg_we;
  logic            cmd_valid, cmd_ready;
  qiwt_pkg::cmd_t  cmd;
  qiwt_pkg::res_t  res;

  // Register writes land at once; the user must write only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= 7'd16;
      interval_q <= 32'd1000;
    end else if (cfg_we) begin
      case (cfg_index_i)
        qiwt_pkg::CFG_WINDOW:   window_q   <= cfg_data_i[6:0];
        qiwt_pkg::CFG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Writing the start id reseeds the id counter in the engine.
  assign cfg.window   = window_q;
  assign cfg.interval = interval_q;
  assign cfg.id_load  = cfg_we && (cfg_index_i == qiwt_pkg::CFG_START_ID);
  assign cfg.id_seed  = cfg_data_i[15:0];

  // Front: decode each word and queue it.
  qiwt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .pid_i       (s_axis_tdata[15:0]),
    .qos_i       (s_axis_tdata[17:16]),
    .now_i       (s_axis_tdata[49:18]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: walk the entry store and produce result words.
  qiwt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {3'd0, res.ovf, res.matched, res.retx, res.qos, res.pid};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

### tb/qos_window_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// qos_window_checker
// Watches the input, result and register channels of the window tracker.
// Keeps its own copy of the entry queue, predicts the result words of every
// accepted input word and compares them in order with the words the block
// delivers.
// ----------------------------------------------------------------------------
module qos_window_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [55:0] in_data_i,
  input  wire  [2:0]  in_op_i,
  input  wire         res_valid_i,
  input  wire         res_ready_i,
  input  wire  [23:0] res_data_i,
  input  wire  [1:0]  res_action_i,
  input  wire         res_last_i,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  qiwt_pkg::entry_t store [qiwt_pkg::QueueDepth];
  int unsigned      queued;
  int unsigned      in_flight;
  logic [15:0]      id_ctr;
  logic [6:0]       window;
  logic [31:0]      interval;
  qiwt_pkg::res_t   sends_q [$];

  function automatic qiwt_pkg::res_t make_res(logic [1:0] act, logic [15:0] pid,
                                              logic [1:0] qos, logic retx, logic matched,
                                              logic ovf);
    qiwt_pkg::res_t r;
    r = '0;
    r.action  = act;
    r.pid     = pid;
    r.qos     = qos;
    r.retx    = retx;
    r.matched = matched;
    r.ovf     = ovf;
    return r;
  endfunction

  function automatic void push_entry(int unsigned k, logic retx, logic matched);
    if (store[k].rel)
      sends_q.push_back(make_res(qiwt_pkg::ACT_PUBREL, store[k].id, 2'd0, retx, matched,
                                 1'b0));
    else
      sends_q.push_back(make_res(qiwt_pkg::ACT_PUBLISH, store[k].id, store[k].lvl, retx,
                                 matched, 1'b0));
  endfunction

  // Append at the tail; report whether it went straight into flight.
  function automatic bit append(logic [15:0] id, logic rel, logic [1:0] lvl, logic [31:0] now);
    if (queued >= qiwt_pkg::QueueDepth) return 1'b0;
    store[queued] = '{id: id, rel: rel, lvl: lvl, sent: 32'd0};
    queued++;
    if (in_flight < window && in_flight < queued) begin
      store[queued-1].sent = now;
      in_flight++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict(logic [2:0] op, logic [15:0] pid, logic [1:0] qos,
                                  logic [31:0] now);
    int unsigned base;
    logic        matched;
    logic        want_rel;
    logic [1:0]  want_lvl;
    logic [15:0] id;
    logic [31:0] age;
    base    = sends_q.size();
    matched = 1'b0;
    case (op)
      qiwt_pkg::OP_PUBLISH: begin
        if (qos == 2'd0) begin
          sends_q.push_back(make_res(qiwt_pkg::ACT_PUBLISH, 16'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        end else if (qos <= 2'd2) begin
          id     = id_ctr;
          id_ctr = id_ctr + 16'd1;
          if (queued >= qiwt_pkg::QueueDepth) begin
            sends_q.push_back(make_res(qiwt_pkg::ACT_NONE, id, 2'd0, 1'b0, 1'b0, 1'b1));
          end else if (queued == in_flight && append(id, 1'b0, qos, now)) begin
            sends_q.push_back(make_res(qiwt_pkg::ACT_PUBLISH, id, qos, 1'b0, 1'b0, 1'b0));
          end else if (queued < qiwt_pkg::QueueDepth &&
                       !(queued > 0 && store[queued-1].id == id &&
                         store[queued-1].lvl == qos && !store[queued-1].rel &&
                         queued > in_flight)) begin
            // wait behind the entries already queued
            store[queued] = '{id: id, rel: 1'b0, lvl: qos, sent: 32'd0};
            queued++;
          end
        end
      end
      qiwt_pkg::OP_PUBACK, qiwt_pkg::OP_PUBREC, qiwt_pkg::OP_PUBCOMP: begin
        want_rel = (op == qiwt_pkg::OP_PUBCOMP);
        want_lvl = (op == qiwt_pkg::OP_PUBACK) ? 2'd1 : 2'd2;
        for (int unsigned i = 0; i < in_flight && i < queued; i++) begin
          if (store[i].id != pid || store[i].rel != want_rel) continue;
          if (!want_rel && store[i].lvl != want_lvl) continue;
          for (int unsigned j = i; j + 1 < queued; j++) store[j] = store[j+1];
          queued--;
          in_flight--;
          matched = 1'b1;
          break;
        end
        if (matched) begin
          // promote the first waiting entry
          if (queued > in_flight) begin
            store[in_flight].sent = now;
            push_entry(in_flight, 1'b0, 1'b1);
            in_flight++;
          end
          if (op == qiwt_pkg::OP_PUBREC) begin
            if (queued == in_flight) begin
              if (append(pid, 1'b1, 2'd0, now))
                sends_q.push_back(make_res(qiwt_pkg::ACT_PUBREL, pid, 2'd0, 1'b0, 1'b1,
                                           1'b0));
            end else if (queued < qiwt_pkg::QueueDepth) begin
              store[queued] = '{id: pid, rel: 1'b1, lvl: 2'd0, sent: 32'd0};
              queued++;
            end
          end
        end
      end
      qiwt_pkg::OP_TICK: begin
        for (int unsigned i = 0; i < in_flight && i < queued; i++) begin
          age = now - store[i].sent;
          if (age >= interval) push_entry(i, 1'b1, 1'b0);
        end
      end
      default: ;
    endcase
    if (sends_q.size() == base)
      sends_q.push_back(make_res(qiwt_pkg::ACT_NONE, 16'd0, 2'd0, 1'b0, matched, 1'b0));
    sends_q[sends_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    qiwt_pkg::res_t got;
    qiwt_pkg::res_t want;
    if (!rst_ni) begin
      queued    = 0;
      in_flight = 0;
      id_ctr    = 16'd0;
      window    = 7'd16;
      interval  = 32'd1000;
      errors_o  <= 0;
      sends_q.delete();
      pending_o = 0;
    end else begin
      // check first: a word delivered now never stems from an input taken now
      if (res_valid_i && res_ready_i) begin
        got         = '0;
        got.action  = res_action_i;
        got.pid     = res_data_i[15:0];
        got.qos     = res_data_i[17:16];
        got.retx    = res_data_i[18];
        got.matched = res_data_i[19];
        got.ovf     = res_data_i[20];
        got.last    = res_last_i;
        if (sends_q.size() == 0) begin
          $display("%0t unexpected result: expected none got %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = sends_q.pop_front();
          if (got != want) begin
            $display("%0t result mismatch: expected %p got %p", $time, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          qiwt_pkg::CFG_WINDOW:   window   = cfg_data_i[6:0];
          qiwt_pkg::CFG_INTERVAL: interval = cfg_data_i;
          qiwt_pkg::CFG_START_ID: id_ctr   = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict(in_op_i, in_data_i[15:0], in_data_i[17:16], in_data_i[49:18]);
      pending_o = sends_q.size();
    end
  end

endmodule
`default_nettype wire

### tb/qos_inflight_window_tracker_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// qos_inflight_window_tracker_test
// Drives publishes, acknowledgements and timer ticks into the window tracker
// under random stalls on both sides, several register settings and a long
// receiver hold-off; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module qos_inflight_window_tracker_test;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int          errors;
  int          pending;
  bit          calm;          // no idling on either side while set
  int          hold_reqs;     // bumped to ask the receiver for a long hold-off
  logic [31:0] now_t;
  logic [15:0] id_shadow;     // best guess of the next id the block hands out

  // outstanding publishes the stimulus may acknowledge
  typedef struct {
    logic [15:0] id;
    logic [1:0]  lvl;
    bit          rel;
  } open_pub_t;
  open_pub_t open_pubs [$];

  qos_inflight_window_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  qos_window_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_op_i      (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_action_i (m_axis_tuser),
    .res_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int seen;
    int hold_left;
    seen      = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != seen) begin
        seen      = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, quiet);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == qiwt_pkg::CFG_START_ID) id_shadow = data[15:0];
  endtask

  // Offer one input word and hold it until it is taken.
  task automatic send_item(logic [2:0] op, logic [15:0] pid, logic [1:0] qos);
    if (!calm && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, now_t, qos, pid};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain every expected word, then give the block time to finish a scan.
  task automatic wait_idle();
    stop_sending();
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic publish(logic [1:0] qos);
    open_pub_t p;
    send_item(qiwt_pkg::OP_PUBLISH, 16'($urandom), qos);
    if (qos == 2'd1 || qos == 2'd2) begin
      p = '{id: id_shadow, lvl: qos, rel: 1'b0};
      if (open_pubs.size() >= 90) void'(open_pubs.pop_front());
      open_pubs.push_back(p);
      id_shadow++;
    end
  endtask

  // Mostly well-formed traffic: publishes and the acks they call for.
  task automatic random_item();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) now_t = now_t + $urandom;
    else now_t = now_t + $urandom_range(0, 400);
    if (r < 45) begin
      publish(2'($urandom_range(1, 2)));
    end else if (r < 50) begin
      publish($urandom_range(0, 1) ? 2'd3 : 2'd0);
    end else if (r < 82 && open_pubs.size() > 0) begin
      k = $urandom_range(0, open_pubs.size() - 1);
      if (open_pubs[k].rel) begin
        send_item(qiwt_pkg::OP_PUBCOMP, open_pubs[k].id, 2'($urandom));
        open_pubs.delete(k);
      end else if (open_pubs[k].lvl == 2'd1) begin
        send_item(qiwt_pkg::OP_PUBACK, open_pubs[k].id, 2'($urandom));
        open_pubs.delete(k);
      end else begin
        send_item(qiwt_pkg::OP_PUBREC, open_pubs[k].id, 2'($urandom));
        open_pubs[k].rel = 1'b1;
      end
    end else if (r < 92) begin
      send_item(qiwt_pkg::OP_TICK, 16'($urandom), 2'($urandom));
    end else begin
      // noise: any op code, any id
      send_item(3'($urandom_range(0, 7)), 16'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    logic [6:0]  windows   [4];
    logic [31:0] intervals [4];
    windows   = '{7'd64, 7'd16, 7'd4, 7'd1};
    intervals = '{32'd500, 32'd0, 32'hFFFF_FFFF, 32'd120};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    hold_reqs     = 0;
    now_t         = 32'd0;
    id_shadow     = 16'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: ids wrap past the top, window of two, resend on every tick.
    cfg_write(qiwt_pkg::CFG_START_ID, 32'd65534);
    cfg_write(qiwt_pkg::CFG_WINDOW, 32'd2);
    cfg_write(qiwt_pkg::CFG_INTERVAL, 32'd0);
    send_item(qiwt_pkg::OP_PUBLISH, 16'hFFFF, 2'd0);   // qos zero goes out at once with id zero
    send_item(qiwt_pkg::OP_PUBLISH, 16'h0000, 2'd3);   // qos three is ignored
    send_item(3'd5, 16'hFFFF, 2'd3);                   // unknown ops do nothing
    send_item(3'd6, 16'h5A5A, 2'd1);
    send_item(3'd7, 16'hA5A5, 2'd2);
    send_item(qiwt_pkg::OP_PUBACK, 16'd1234, 2'd0);    // nothing in flight: unmatched
    send_item(qiwt_pkg::OP_PUBLISH, 16'd0, 2'd1);      // id 65534, in flight
    send_item(qiwt_pkg::OP_PUBLISH, 16'd0, 2'd2);      // id 65535, in flight
    send_item(qiwt_pkg::OP_PUBLISH, 16'd0, 2'd1);      // id 0 wraps, window full: waits
    now_t = 32'hFFFF_FFF0;
    send_item(qiwt_pkg::OP_TICK, 16'd0, 2'd0);         // resend both in flight
    now_t = 32'h0000_0010;                             // age crosses the 2^32 wrap
    send_item(qiwt_pkg::OP_PUBACK, 16'd65534, 2'd0);   // matched: id 0 promoted
    send_item(qiwt_pkg::OP_PUBREC, 16'd65535, 2'd0);   // matched: pubrel queued behind
    send_item(qiwt_pkg::OP_PUBACK, 16'd65535, 2'd0);   // wrong kind for a qos two id
    send_item(qiwt_pkg::OP_PUBCOMP, 16'd65535, 2'd0);  // pubrel in flight: matched
    send_item(qiwt_pkg::OP_PUBACK, 16'd0, 2'd0);
    send_item(qiwt_pkg::OP_PUBREC, 16'd0, 2'd0);       // already gone: unmatched
    send_item(qiwt_pkg::OP_TICK, 16'hFFFF, 2'd3);      // nothing left to resend
    wait_idle();

    // Fill the queue past its depth while the receiver holds off.
    cfg_write(qiwt_pkg::CFG_WINDOW, 32'd1);
    cfg_write(qiwt_pkg::CFG_INTERVAL, 32'hFFFF_FFFF);
    cfg_write(qiwt_pkg::CFG_START_ID, 32'd100);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 70; i++) publish((i % 2) ? 2'd2 : 2'd1);
    send_item(qiwt_pkg::OP_TICK, 16'd0, 2'd0);
    wait_idle();

    // Window of zero: nothing goes into flight.
    cfg_write(qiwt_pkg::CFG_WINDOW, 32'd0);
    for (int i = 0; i < 6; i++) random_item();
    wait_idle();

    // Random phases over several settings; one of them with no idling at all.
    for (int p = 0; p < 4; p++) begin
      cfg_write(qiwt_pkg::CFG_WINDOW, 32'(windows[p]));
      cfg_write(qiwt_pkg::CFG_INTERVAL, intervals[p]);
      if (p == 2) cfg_write(qiwt_pkg::CFG_START_ID, $urandom_range(0, 65535));
      if (p == 3) cfg_write(qiwt_pkg::CFG_START_ID, 32'd65535);
      calm = (p == 1);
      for (int i = 0; i < 30; i++) random_item();
      wait_idle();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
